// File: src/dmxser_pkg.sv
// Shared constants and types for the DMX512 multi-universe bit serializer.
package dmxser_pkg;

    // Default configuration.
    localparam int UNIVERSES_DEF = 16;
    localparam int SLOTS_DEF     = 512;
    localparam int MARK_BITS_DEF = 4;

    // Line format.
    localparam int LANES_OUT       = 16;
    localparam int BYTE_FRAME_BITS = 11;
    localparam int BYTE_BITS       = 8;

    // Word field widths.
    localparam int UNIVERSE_W = 4;
    localparam int SLOT_W     = 9;

    typedef enum logic [0:0] {
        CMD_WRITE = 1'b0,
        CMD_EMIT  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        PH_MARK,
        PH_FRAME,
        PH_LAST
    } t_phase;

endpackage

// File: src/dmxser_if.sv
// Valid/ready channels for command words and bit-time words.
interface dmxser_in_if;
    logic                                valid;
    logic                                ready;
    logic                                command;
    logic [dmxser_pkg::UNIVERSE_W-1:0]   universe;
    logic [dmxser_pkg::SLOT_W-1:0]       slot;
    logic [dmxser_pkg::BYTE_BITS-1:0]    slot_value;

    modport source (output valid, command, universe, slot, slot_value, input ready);
    modport sink   (input valid, command, universe, slot, slot_value, output ready);
endinterface

interface dmxser_out_if;
    logic                                valid;
    logic                                ready;
    logic [dmxser_pkg::LANES_OUT-1:0]    line_levels;
    logic                                frame_end;

    modport source (output valid, line_levels, frame_end, input ready);
    modport sink   (input valid, line_levels, frame_end, output ready);
endinterface

// File: src/dmx512_multi_universe_bit_serializer.sv
// Top level of the DMX512 multi-universe bit serializer.

// Holds one byte per universe and slot and turns it into parallel DMX512
// bit-time words, one bit per universe. A command word with command 0 stores
// slot_value at (universe, slot); out-of-range writes are dropped. A command
// word with command 1 produces the next bit-time word: MARK_BITS marks at 1,
// the start code frame, SLOTS slot frames (start bit 0, 8 data bits LSB first,
// two stop bits at 1), then one 0 word flagged with frame_end, after which the
// frame restarts. With the defaults a frame is 5648 words. The store is a
// single RAM with one row per slot holding all lanes side by side; a slot's
// row is read once at its start bit and held, with writes to that row merged
// in. One command word is taken per cycle, sustained, limited by the output
// register draining and the clearing pass. After reset a clearing pass zeroes
// the store one row per cycle, during which no command word is accepted.
module dmx512_multi_universe_bit_serializer #(
    parameter int UNIVERSES = dmxser_pkg::UNIVERSES_DEF,
    parameter int SLOTS     = dmxser_pkg::SLOTS_DEF,
    parameter int MARK_BITS = dmxser_pkg::MARK_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    dmxser_in_if.sink            i_cmd,
    dmxser_out_if.source         o_word
);

    // Lanes beyond the output width are never addressable; keep them out.
    localparam int LANES  = (UNIVERSES < dmxser_pkg::LANES_OUT) ?
                            UNIVERSES : dmxser_pkg::LANES_OUT;
    localparam int BB     = dmxser_pkg::BYTE_BITS;
    localparam int ROW_W  = LANES * BB;
    localparam int LW     = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FW     = $clog2(SLOTS + 1);
    localparam int MW     = (MARK_BITS > 1) ? $clog2(MARK_BITS) : 1;
    localparam int OW     = dmxser_pkg::LANES_OUT;
    localparam logic [OW-1:0] LANE_MASK = OW'((33'h1 << LANES) - 33'h1);
    localparam logic [3:0] LAST_BIT = 4'(dmxser_pkg::BYTE_FRAME_BITS - 1);
    localparam logic [3:0] STOP_BIT = 4'(BB + 1);

    // Slot store: one row per slot, one byte per lane.
    logic [ROW_W-1:0] r_mem [SLOTS];
    logic [ROW_W-1:0] r_q;

    // Control state.
    dmxser_pkg::t_phase r_phase, n_phase;
    logic [MW-1:0]      r_mark,  n_mark;
    logic [3:0]         r_bit,   n_bit;
    logic [FW-1:0]      r_frame, n_frame;
    logic               r_load;
    logic               r_clr_busy;
    logic [SW-1:0]      r_clr_addr;

    // Held row of the current slot frame.
    logic [ROW_W-1:0]   r_row, n_row;
    logic [ROW_W-1:0]   row_now;

    // Output register.
    logic               r_out_valid;
    logic [OW-1:0]      r_out_levels;
    logic               r_out_end;

    logic               in_fire, emit, wr_ok, wr_hit;
    logic [SW-1:0]      wr_addr;
    logic [LW-1:0]      wr_lane;
    logic               rd_en;
    logic [SW-1:0]      rd_addr;
    logic [OW-1:0]      levels;
    logic               frame_end;
    logic [FW-1:0]      cur_row;
    logic [2:0]         data_idx;

    // Accept while not clearing and the output register can take a word.
    assign i_cmd.ready = !r_clr_busy && (!r_out_valid || o_word.ready);
    assign in_fire     = i_cmd.valid && i_cmd.ready;
    assign emit        = in_fire && (i_cmd.command == dmxser_pkg::CMD_EMIT);
    assign wr_ok       = in_fire && (i_cmd.command == dmxser_pkg::CMD_WRITE)
                         && (32'(i_cmd.universe) < UNIVERSES)
                         && (32'(i_cmd.slot) < SLOTS);
    assign wr_addr     = i_cmd.slot[SW-1:0];
    assign wr_lane     = LW'(i_cmd.universe);

    // Slot frame f uses row f-1; the start code frame has no row.
    assign cur_row  = r_frame - FW'(1);
    assign wr_hit   = wr_ok && (r_phase == dmxser_pkg::PH_FRAME) && (r_frame != '0)
                      && (wr_addr == cur_row[SW-1:0]);
    assign data_idx = 3'(r_bit - 4'd1);

    // Take fresh read data in the cycle after the start bit, else the held row.
    assign row_now = r_load ? r_q : r_row;

    always_comb begin
        n_row = row_now;
        if (wr_hit) begin
            n_row[wr_lane*BB +: BB] = i_cmd.slot_value;
        end
    end

    // Next phase, counters, read issue and the word itself.
    always_comb begin
        n_phase   = r_phase;
        n_mark    = r_mark;
        n_bit     = r_bit;
        n_frame   = r_frame;
        rd_en     = 1'b0;
        rd_addr   = cur_row[SW-1:0];
        levels    = '0;
        frame_end = 1'b0;
        case (r_phase)
            dmxser_pkg::PH_MARK: begin
                levels = LANE_MASK;
                if (emit) begin
                    if (r_mark == MW'(MARK_BITS - 1)) begin
                        n_phase = dmxser_pkg::PH_FRAME;
                        n_bit   = '0;
                        n_frame = '0;
                    end else begin
                        n_mark = r_mark + MW'(1);
                    end
                end
            end
            dmxser_pkg::PH_FRAME: begin
                if (r_bit == 4'd0) begin
                    levels = '0;
                    // Fetch this slot's row while the start bit goes out.
                    rd_en  = emit && (r_frame != '0);
                end else if (r_bit >= STOP_BIT) begin
                    levels = LANE_MASK;
                end else if (r_frame != '0) begin
                    for (int l = 0; l < LANES; l++) begin
                        levels[l] = row_now[l*BB + 32'(data_idx)];
                    end
                end
                if (emit) begin
                    if (r_bit == LAST_BIT) begin
                        n_bit = '0;
                        if (r_frame == FW'(SLOTS)) begin
                            n_phase = dmxser_pkg::PH_LAST;
                        end else begin
                            n_frame = r_frame + FW'(1);
                        end
                    end else begin
                        n_bit = r_bit + 4'd1;
                    end
                end
            end
            dmxser_pkg::PH_LAST: begin
                levels    = '0;
                frame_end = 1'b1;
                if (emit) begin
                    n_phase = dmxser_pkg::PH_MARK;
                    n_mark  = '0;
                end
            end
            default: begin
                n_phase = dmxser_pkg::PH_MARK;
                n_mark  = '0;
            end
        endcase
    end

    // Phase and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= dmxser_pkg::PH_MARK;
            r_mark  <= '0;
            r_bit   <= '0;
            r_frame <= '0;
            r_load  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_mark  <= n_mark;
            r_bit   <= n_bit;
            r_frame <= n_frame;
            r_load  <= rd_en;
        end
    end

    // Clearing pass after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == SW'(SLOTS - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + SW'(1);
        end
    end

    // Store write port: clear rows, else write one lane's byte.
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (wr_ok) begin
            r_mem[wr_addr][wr_lane*BB +: BB] <= i_cmd.slot_value;
        end
    end

    // Store read port, registered; hold data between reads.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_q <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_word.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_levels <= levels;
            r_out_end    <= frame_end;
        end
    end

    assign o_word.valid       = r_out_valid;
    assign o_word.line_levels = r_out_levels;
    assign o_word.frame_end   = r_out_end;

`ifndef NO_ASSERTIONS
    // The closing word of a frame is always a low line.
    a_end_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_word.valid && o_word.frame_end) |-> (o_word.line_levels == '0))
        else $error("frame_end word carries nonzero levels");

    // An emit of the closing word restarts the marks.
    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && r_phase == dmxser_pkg::PH_LAST)
        |=> (r_phase == dmxser_pkg::PH_MARK && r_mark == '0))
        else $error("frame did not wrap to marks");

    // Bit and frame counters stay inside the frame layout.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == dmxser_pkg::PH_FRAME) |-> (r_bit <= LAST_BIT && r_frame <= FW'(SLOTS)))
        else $error("bit or frame counter out of range");

    // Fresh row data arrives only right after a start-bit emit.
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load |-> ($past(emit) && $past(r_bit) == 4'd0 && r_bit == 4'd1))
        else $error("row load outside first data bit");
`endif

endmodule
